FILE: hw/rtl/trme_pkg.sv
// ----------------------------------------------------------------------------
// trme_pkg: shared types and constants
// field layouts of the request and response transactions, opcodes, codes
// ----------------------------------------------------------------------------
package trme_pkg;

   localparam int WORD_BITS = 32;
   localparam int ADDR_BITS = 16;
   localparam int NUM_REGS  = 5;
   localparam int REG_BITS  = 3;
   localparam int RIDX_BITS = 3;
   localparam int CNT_BITS  = 6;

   localparam logic [3:0] OP_NOOP = 4'd0;
   localparam logic [3:0] OP_JMP  = 4'd1;
   localparam logic [3:0] OP_MOV  = 4'd2;
   localparam logic [3:0] OP_INC  = 4'd3;
   localparam logic [3:0] OP_DEC  = 4'd4;
   localparam logic [3:0] OP_ADD  = 4'd5;
   localparam logic [3:0] OP_MUL  = 4'd6;
   localparam logic [3:0] OP_DIV  = 4'd7;
   localparam logic [3:0] OP_JZ   = 4'd8;
   localparam logic [3:0] OP_END  = 4'd9;

   localparam logic [1:0] IRQ_NONE    = 2'd0;
   localparam logic [1:0] IRQ_ABEND   = 2'd1;
   localparam logic [1:0] IRQ_END     = 2'd2;
   localparam logic [1:0] IRQ_QUANTUM = 2'd3;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EXEC = 1'b1;

   localparam logic [0:0] CSR_ADDRESS_LIMIT  = 1'd0;
   localparam logic [0:0] CSR_QUANTUM_LENGTH = 1'd1;

   typedef struct packed {
      logic                 kind;
      logic [3:0]           opcode;
      logic [REG_BITS-1:0]  first_reg;
      logic [REG_BITS-1:0]  second_reg;
      logic signed [31:0]   operand_value;
   } req_type;

   typedef struct packed {
      logic [1:0]           interrupt_code;
      logic [ADDR_BITS-1:0] fetch_address;
      logic [ADDR_BITS-1:0] next_pc;
   } rsp_type;

endpackage

FILE: hw/rtl/toy_register_machine_execute.sv
// ----------------------------------------------------------------------------
// toy_register_machine_execute: five-register machine execute unit
// queues decoded instructions and executes them one at a time
// ----------------------------------------------------------------------------
//  channel | ports           | transaction
//  req     | req_valid/ready | load pc or one decoded instruction
//  rsp     | rsp_valid/ready | interrupt code, fetch address, next pc
//  csr     | psel..pready    | address_limit (0x0), quantum_length (0x4)
//
// a request passes the queue and the backend result register before its response;
// mul also passes the product register, and div the operand latch, the start
// register and the one-bit-per-cycle restoring divider
// reset clears registers, pc and quantum count at once; no clearing pass
// a two-entry queue keeps accepting transactions while execution stalls, until full
// a stalled response holds the backend until it is taken
module toy_register_machine_execute (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  trme_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output trme_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   logic [15:0] limit_ff, qlen_ff;
   logic        q_valid, q_ready;
   trme_pkg::req_type q_data;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 16'hFFFF;
         qlen_ff  <= 16'd16;
      end else if (csr_wr) begin
         unique case (paddr[2])
            trme_pkg::CSR_ADDRESS_LIMIT:  limit_ff <= pwdata[15:0];
            trme_pkg::CSR_QUANTUM_LENGTH: qlen_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr[2])
         trme_pkg::CSR_ADDRESS_LIMIT:  prdata = {16'd0, limit_ff};
         trme_pkg::CSR_QUANTUM_LENGTH: prdata = {16'd0, qlen_ff};
         default: ;
      endcase
   end

   // front: request queue
   trme_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   // back: execution
   trme_backend u_backend (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (q_valid),
      .in_ready       (q_ready),
      .in_data        (q_data),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .out_data       (rsp_data),
      .address_limit  (limit_ff),
      .quantum_length (qlen_ff)
   );

   // a load transaction restarts with zero fetch address
   assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready && q_data.kind == trme_pkg::KIND_LOAD) |=>
      (rsp_valid && rsp_data.fetch_address == '0))
      else $error("load response fetch address not zero");

   // no new instruction enters while a result is stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !q_ready)
      else $error("backend accepted while response stalled");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      ($past(rsp_valid && !rsp_ready) && !$past(reset)) |-> $stable(rsp_data))
      else $error("stalled response changed");
endmodule

FILE: hw/rtl/trme_queue.sv
// ----------------------------------------------------------------------------
// trme_queue: two-entry request queue
// decouples request acceptance from execution
// ----------------------------------------------------------------------------
module trme_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  trme_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output trme_pkg::req_type out_data
);
   trme_pkg::req_type mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= in_data;
      end
   end
endmodule

FILE: hw/rtl/trme_divider.sv
// ----------------------------------------------------------------------------
// trme_divider: signed truncating divider
// restoring, one quotient bit per cycle
// ----------------------------------------------------------------------------
module trme_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [trme_pkg::WORD_BITS-1:0]  dividend,
   input  logic [trme_pkg::WORD_BITS-1:0]  divisor,
   output logic                            busy,
   output logic                            done,
   output logic [trme_pkg::WORD_BITS-1:0]  quotient
);
   localparam int W = trme_pkg::WORD_BITS;

   logic [W-1:0] q_ff, q_in, d_ff, d_in;
   logic [W:0]   rem_ff, rem_in;
   logic         neg_ff, neg_in;
   logic [trme_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [W:0]   trial;
   logic [W-1:0] mag_a, mag_b;

   assign mag_a = dividend[W-1] ? (~dividend + 1'b1) : dividend;
   assign mag_b = divisor[W-1] ? (~divisor + 1'b1) : divisor;
   assign trial = {rem_ff[W-1:0], q_ff[W-1]} - {1'b0, d_ff};

   always_comb begin
      q_in = q_ff; d_in = d_ff; rem_in = rem_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         q_in    = mag_a;
         d_in    = mag_b;
         rem_in  = '0;
         neg_in  = dividend[W-1] ^ divisor[W-1];
         cnt_in  = trme_pkg::CNT_BITS'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[W]) begin
            rem_in = {rem_ff[W-1:0], q_ff[W-1]};
            q_in   = {q_ff[W-2:0], 1'b0};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == trme_pkg::CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? (~q_ff + 1'b1) : q_ff;
endmodule

FILE: hw/rtl/trme_backend.sv
// ----------------------------------------------------------------------------
// trme_backend: instruction execution
// register file, pc, quantum count, result register
// ----------------------------------------------------------------------------
module trme_backend (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  trme_pkg::req_type               in_data,
   output logic                            out_valid,
   input  logic                            out_ready,
   output trme_pkg::rsp_type               out_data,
   input  logic [trme_pkg::ADDR_BITS-1:0]  address_limit,
   input  logic [15:0]                     quantum_length
);
   localparam int W = trme_pkg::WORD_BITS;
   localparam int A = trme_pkg::ADDR_BITS;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_MUL  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [W-1:0] rf_ff [trme_pkg::NUM_REGS];
   logic [A-1:0] pc_ff, pc_in;
   logic [15:0]  qc_ff;
   logic [15:0]  qc_inc;
   logic         ov_ff;
   trme_pkg::rsp_type rsp_ff;
   logic [trme_pkg::RIDX_BITS-1:0] didx_ff;
   logic [W-1:0] prod_ff, dvd_ff, dvs_ff;
   logic [A-1:0] fetch_ff;

   // divider start is registered at the same edge that latches the operands
   logic         dstart_ff, div_busy, div_done;
   logic [W-1:0] quot;

   logic fire, r1ok, r2ok, need1, need2, bad, fault;
   logic [trme_pkg::RIDX_BITS-1:0] i1, i2;
   logic [W-1:0] dv, sv;
   logic [A-1:0] fetch, pc_inc;
   logic [1:0]   code;
   logic         wr_en;
   logic [W-1:0] wr_val;
   logic         count_ok;

   assign in_ready = (state_ff == ST_IDLE) && !div_busy && !(ov_ff && !out_ready);
   assign fire     = in_valid && in_ready;
   assign out_valid = ov_ff;
   assign out_data  = rsp_ff;

   assign i1 = in_data.first_reg - 1'b1;
   assign i2 = in_data.second_reg - 1'b1;
   assign r1ok = (in_data.first_reg >= 3'd1) && (in_data.first_reg <= 3'd5);
   assign r2ok = (in_data.second_reg >= 3'd1) && (in_data.second_reg <= 3'd5);
   assign need1 = (in_data.opcode >= trme_pkg::OP_MOV) && (in_data.opcode <= trme_pkg::OP_JZ);
   assign need2 = (in_data.opcode >= trme_pkg::OP_ADD) && (in_data.opcode <= trme_pkg::OP_JZ);
   assign dv = r1ok ? rf_ff[i1] : '0;
   assign sv = r2ok ? rf_ff[i2] : '0;
   assign fetch  = pc_ff;
   assign pc_inc = pc_ff + 1'b1;
   assign bad = (in_data.opcode > trme_pkg::OP_END) || (need1 && !r1ok) || (need2 && !r2ok);
   assign fault = fetch > address_limit;
   assign qc_inc = qc_ff + 1'b1;

   trme_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dstart_ff),
      .dividend (dvd_ff),
      .divisor  (dvs_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      code     = trme_pkg::IRQ_NONE;
      wr_en    = 1'b0;
      wr_val   = dv;
      count_ok = 1'b0;
      if (fire) begin
         if (in_data.kind == trme_pkg::KIND_LOAD) begin
            pc_in = in_data.operand_value[A-1:0];
         end else begin
            pc_in = pc_inc;
            if (fault || bad) begin
               code = trme_pkg::IRQ_ABEND;
            end else begin
               count_ok = 1'b1;
               unique case (in_data.opcode)
                  trme_pkg::OP_JMP: pc_in = in_data.operand_value[A-1:0];
                  trme_pkg::OP_MOV: begin
                     wr_en = 1'b1; wr_val = W'(in_data.operand_value);
                  end
                  trme_pkg::OP_INC: begin wr_en = 1'b1; wr_val = dv + 1'b1; end
                  trme_pkg::OP_DEC: begin wr_en = 1'b1; wr_val = dv - 1'b1; end
                  trme_pkg::OP_ADD: begin wr_en = 1'b1; wr_val = dv + sv; end
                  trme_pkg::OP_MUL: begin count_ok = 1'b0; state_in = ST_MUL; end
                  trme_pkg::OP_DIV: begin
                     count_ok = 1'b0;
                     if (sv == '0) code = trme_pkg::IRQ_ABEND;
                     else state_in = ST_DIV;
                  end
                  trme_pkg::OP_JZ: if (dv == '0) pc_in = sv[A-1:0];
                  trme_pkg::OP_END: begin count_ok = 1'b0; code = trme_pkg::IRQ_END; end
                  default: ;
               endcase
            end
         end
      end else if (state_ff == ST_MUL) begin
         state_in = ST_IDLE;
         wr_en = 1'b1; wr_val = prod_ff; count_ok = 1'b1;
      end else if (state_ff == ST_DIV && div_done) begin
         state_in = ST_IDLE;
         wr_en = 1'b1; wr_val = quot; count_ok = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pc_ff     <= '0;
         qc_ff     <= '0;
         ov_ff     <= 1'b0;
         dstart_ff <= 1'b0;
         for (int k = 0; k < trme_pkg::NUM_REGS; k++) rf_ff[k] <= '0;
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         dstart_ff <= fire && (state_in == ST_DIV);
         if (wr_en) begin
            rf_ff[fire ? i1 : didx_ff] <= wr_val;
         end
         if (out_valid && out_ready) ov_ff <= 1'b0;
         if (fire && in_data.kind == trme_pkg::KIND_LOAD) begin
            qc_ff <= '0;
            ov_ff <= 1'b1;
            rsp_ff <= '{trme_pkg::IRQ_NONE, '0, pc_in};
         end else if (count_ok) begin
            ov_ff <= 1'b1;
            if (qc_inc >= quantum_length) begin
               qc_ff <= '0;
               rsp_ff <= '{trme_pkg::IRQ_QUANTUM, fire ? fetch : fetch_ff, pc_in};
            end else begin
               qc_ff <= qc_inc;
               rsp_ff <= '{trme_pkg::IRQ_NONE, fire ? fetch : fetch_ff, pc_in};
            end
         end else if (fire && state_in == ST_IDLE) begin
            ov_ff <= 1'b1;
            rsp_ff <= '{code, fetch, pc_in};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         didx_ff  <= i1;
         fetch_ff <= fetch;
         prod_ff  <= dv * sv;
         dvd_ff   <= dv;
         dvs_ff   <= sv;
      end
   end
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: execute unit testbench
// drives load and instruction transactions with random idling, predicts each
// response from a private machine model, compares it whole and reports a mismatch field by field
// ----------------------------------------------------------------------------
import trme_pkg::*;

// in-order store of predicted responses plus the machine state they come from
class exec_scoreboard;
   logic [WORD_BITS-1:0] regs [NUM_REGS];
   logic [ADDR_BITS-1:0] pc;
   logic [15:0]          qcount;
   logic [15:0]          addr_limit;
   logic [15:0]          quantum_len;
   rsp_type              pending [$];
   int                   mismatches;
   int                   checked;
   int                   code_seen [4];

   function void clear_state();
      for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
      pc          = '0;
      qcount      = '0;
      addr_limit  = 16'hffff;
      quantum_len = 16'd16;
   endfunction

   function automatic logic reg_ok(logic [2:0] r);
      return r >= 1 && r <= NUM_REGS;
   endfunction

   // run one decoded instruction, returns its interrupt code
   function automatic logic [1:0] run_op(req_type t);
      logic need1, need2;
      logic [WORD_BITS-1:0] d, s, q, ma, mb;
      need1 = t.opcode >= OP_MOV && t.opcode <= OP_JZ;
      need2 = t.opcode >= OP_ADD && t.opcode <= OP_JZ;
      if (t.opcode > OP_END) return IRQ_ABEND;
      if ((need1 && !reg_ok(t.first_reg)) || (need2 && !reg_ok(t.second_reg)))
         return IRQ_ABEND;
      d = need1 ? regs[t.first_reg-1] : '0;
      s = need2 ? regs[t.second_reg-1] : '0;
      case (t.opcode)
         OP_JMP: pc = t.operand_value[ADDR_BITS-1:0];
         OP_MOV: d = t.operand_value;
         OP_INC: d = d + 1'b1;
         OP_DEC: d = d - 1'b1;
         OP_ADD: d = d + s;
         OP_MUL: d = d * s;
         OP_DIV: begin
            if (s == 0) return IRQ_ABEND;
            ma = d[WORD_BITS-1] ? -d : d;
            mb = s[WORD_BITS-1] ? -s : s;
            q = ma / mb;
            d = (d[WORD_BITS-1] != s[WORD_BITS-1]) ? -q : q;
         end
         OP_JZ: if (d == 0) pc = s[ADDR_BITS-1:0];
         OP_END: return IRQ_END;
         default: ;
      endcase
      if (need1) regs[t.first_reg-1] = d;
      return IRQ_NONE;
   endfunction

   function void note_request(req_type t);
      rsp_type r;
      r = '0;
      if (t.kind == KIND_LOAD) begin
         pc     = t.operand_value[ADDR_BITS-1:0];
         qcount = '0;
      end else begin
         r.fetch_address = pc;
         pc = pc + 1'b1;
         if (r.fetch_address > addr_limit) r.interrupt_code = IRQ_ABEND;
         else begin
            r.interrupt_code = run_op(t);
            if (r.interrupt_code == IRQ_NONE) begin
               qcount = qcount + 1'b1;
               if (qcount >= quantum_len) begin
                  r.interrupt_code = IRQ_QUANTUM;
                  qcount = '0;
               end
            end
         end
      end
      r.next_pc = pc;
      pending.push_back(r);
   endfunction

   function void check_response(rsp_type got);
      rsp_type want;
      checked++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response %p", got);
         return;
      end
      want = pending.pop_front();
      code_seen[want.interrupt_code]++;
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected code %0d fetch %h pc %h, got code %0d fetch %h pc %h",
                     want.interrupt_code, want.fetch_address, want.next_pc,
                     got.interrupt_code, got.fetch_address, got.next_pc);
      end
   endfunction
endclass

module tb_top;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   exec_scoreboard sb;
   longint cycles = 0;
   logic   rx_idle_on = 1;   // random stalls on the response side
   int     rx_hold = 0;      // long hold-off request, in cycles
   logic   quiet = 0;        // last part of the run, no idling
   int     sent = 0;

   localparam longint CYCLE_LIMIT = 400000;

   always #1 clock = ~clock;

   toy_register_machine_execute uut (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response side: check each transaction, stall in random bursts or on hold
   initial begin
      int gap;
      gap = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (rx_hold > 0) begin
            rsp_ready <= 0;
            rx_hold = rx_hold - 1;
         end else if (gap > 0) begin
            rsp_ready <= 0;
            gap--;
         end else if (!quiet && rx_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 0;
            gap = $urandom_range(0, 13);
         end else rsp_ready <= 1;
         @(posedge clock);
      end
   end

   // apb-style register write in setup and access phases
   task automatic csr_write(logic [0:0] idx, logic [15:0] val);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= {idx, 2'b00}; pwdata <= {16'h0, val};
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      @(posedge clock);
      if (idx == CSR_ADDRESS_LIMIT) sb.addr_limit = val;
      else sb.quantum_len = val;
   endtask

   // block idle: every response has come back, then let the pipe settle
   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // offer one transaction, optionally preceded by a random idle burst
   task automatic send(req_type t);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(t);
      sent++;
   endtask

   task automatic stop_sending();
      req_valid <= 0;
      @(posedge clock);
   endtask

   function automatic req_type mk(logic kind, logic [3:0] op, logic [2:0] a, logic [2:0] b,
                                  logic [31:0] v);
      req_type t;
      t.kind = kind; t.opcode = op; t.first_reg = a; t.second_reg = b;
      t.operand_value = v;
      return t;
   endfunction

   // random instruction, mostly valid registers and known opcodes
   function automatic req_type rand_instr();
      req_type t;
      logic [31:0] v;
      t.kind   = KIND_EXEC;
      t.opcode = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
      t.first_reg  = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(1, 5));
      t.second_reg = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(1, 5));
      case ($urandom_range(0, 5))
         0: v = 32'h8000_0000;
         1: v = 32'hffff_ffff;
         2: v = $urandom_range(0, 3);
         3: v = $urandom_range(0, 40);
         default: v = $urandom;
      endcase
      t.operand_value = v;
      return t;
   endfunction

   initial begin
      sb = new();
      sb.clear_state();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: operand extremes, every opcode, bad registers, div corners
      send(mk(KIND_LOAD, '0, '0, '0, 32'hffff_fffe));
      send(mk(KIND_EXEC, OP_MOV, 3'd1, 3'd7, 32'h8000_0000));
      send(mk(KIND_EXEC, OP_MOV, 3'd2, 3'd0, 32'hffff_ffff));
      send(mk(KIND_EXEC, OP_DIV, 3'd1, 3'd2, '0));   // most negative / -1 wraps
      send(mk(KIND_EXEC, OP_MOV, 3'd5, 3'd1, 32'h7fff_ffff));
      send(mk(KIND_EXEC, OP_INC, 3'd5, 3'd0, '0));
      send(mk(KIND_EXEC, OP_DEC, 3'd3, 3'd0, '0));
      send(mk(KIND_EXEC, OP_ADD, 3'd5, 3'd2, '0));
      send(mk(KIND_EXEC, OP_MUL, 3'd5, 3'd2, '0));
      send(mk(KIND_EXEC, OP_DIV, 3'd5, 3'd4, '0));   // divide by zero
      send(mk(KIND_EXEC, OP_MOV, 3'd4, 3'd0, 32'hffff_fff9));
      send(mk(KIND_EXEC, OP_MOV, 3'd3, 3'd0, 32'd2));
      send(mk(KIND_EXEC, OP_DIV, 3'd4, 3'd3, '0));   // truncates toward zero
      send(mk(KIND_EXEC, OP_INC, 3'd0, 3'd0, '0));   // bad register
      send(mk(KIND_EXEC, OP_ADD, 3'd1, 3'd6, '0));
      send(mk(KIND_EXEC, OP_JZ, 3'd3, 3'd4, '0));
      send(mk(KIND_EXEC, OP_MOV, 3'd2, 3'd7, '0));
      send(mk(KIND_EXEC, OP_JZ, 3'd2, 3'd4, '0));
      send(mk(KIND_EXEC, OP_JMP, 3'd0, 3'd7, 32'h0001_ffff));
      send(mk(KIND_EXEC, OP_NOOP, 3'd7, 3'd7, '0));  // pc wraps at top
      send(mk(KIND_EXEC, 4'd15, 3'd1, 3'd1, '0));
      send(mk(KIND_EXEC, OP_END, 3'd7, 3'd0, '0));
      send(mk(KIND_LOAD, 4'd15, 3'd7, 3'd7, 32'h7fff_0010));
      stop_sending();
      drain();

      // random phases through several register settings, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin csr_write(CSR_ADDRESS_LIMIT, 16'd0); csr_write(CSR_QUANTUM_LENGTH, 16'd1); end
            1: begin csr_write(CSR_ADDRESS_LIMIT, 16'd20); csr_write(CSR_QUANTUM_LENGTH, 16'd0); end
            2: begin
               csr_write(CSR_ADDRESS_LIMIT, 16'hffff);
               csr_write(CSR_QUANTUM_LENGTH, 16'hffff);
            end
            3: begin csr_write(CSR_ADDRESS_LIMIT, 16'd40); csr_write(CSR_QUANTUM_LENGTH, 16'd7); end
            4: begin
               csr_write(CSR_ADDRESS_LIMIT, 16'($urandom_range(10, 200)));
               csr_write(CSR_QUANTUM_LENGTH, 16'($urandom_range(2, 30)));
            end
            default: begin
               csr_write(CSR_ADDRESS_LIMIT, 16'd100);
               csr_write(CSR_QUANTUM_LENGTH, 16'd16);
               quiet = 1;
            end
         endcase
         for (int n = 0; n < 190; n++) begin
            // long receiver hold-off while the sender keeps pushing
            if (ph == 2 && n == 10) rx_hold = 300;
            if (n % 12 == 0 || $urandom_range(0, 19) == 0)
               send(mk(KIND_LOAD, 4'($urandom), 3'($urandom), 3'($urandom),
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60)));
            else send(rand_instr());
         end
         stop_sending();
         drain();
      end

      repeat (50) @(posedge clock);
      $display("sent %0d transactions, checked %0d responses over 7 phases", sent, sb.checked);
      $display("codes: continue %0d abend %0d end %0d quantum %0d",
               sb.code_seen[0], sb.code_seen[1], sb.code_seen[2], sb.code_seen[3]);
      if (sb.mismatches == 0 && sb.pending.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
